/* hw/rtl/joystick_frame_aggregator_top_macros.svh */
// Assertion macros for the joystick frame aggregator.
// Used by the top level; expects signals clk and rst_n in scope.
`ifndef JOYSTICK_FRAME_AGGREGATOR_TOP_MACROS_SVH
`define JOYSTICK_FRAME_AGGREGATOR_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define JFA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define JFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/jfa_pkg.sv */
// Shared types and constants of the joystick frame aggregator.
// Used by jfa_lane, jfa_queue and joystick_frame_aggregator_top.
`timescale 1ns / 1ps
`default_nettype none

package jfa_pkg;

    localparam int TIME_W   = 32;
    localparam int PERIOD_W = 10;
    localparam int BYTE_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int QAW      = 2;
    localparam int QDEPTH   = 1 << QAW;
    localparam int QCNT_W   = QAW + 1;

    // Switch byte direction bits
    localparam int DIR_UP_BIT    = 5;
    localparam int DIR_DOWN_BIT  = 4;
    localparam int DIR_LEFT_BIT  = 3;
    localparam int DIR_RIGHT_BIT = 2;

    localparam logic [BYTE_W-1:0] BTN_MASK   = 8'h80;
    localparam logic [BYTE_W-1:0] HIST_RESET = 8'hFF;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd16;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_P2_ENABLE = 2'd0,
        REG_PERIOD    = 2'd1,
        REG_P1_PREFIX = 2'd2,
        REG_P2_PREFIX = 2'd3
    } jfa_reg_t;

    // One outgoing packet
    typedef struct packed {
        logic              player_index;
        logic [BYTE_W-1:0] command_byte;
        logic [BYTE_W-1:0] switch_byte;
        logic [BYTE_W-1:0] button_byte;
        logic              last_packet;
    } jfa_pkt_t;

    // What a lane found for one poll
    typedef struct packed {
        logic     send;
        jfa_pkt_t pkt;
    } jfa_lane_res_t;

    // Queue status seen by the top level
    typedef struct packed {
        logic              full;
        logic [QCNT_W-1:0] count;
    } jfa_q_status_t;

endpackage

`default_nettype wire

/* hw/rtl/joystick_frame_aggregator_top.sv */
// Top level of the joystick frame aggregator: configuration registers,
// two player lanes and the packet queue. Depends on jfa_pkg, jfa_lane,
// jfa_queue and joystick_frame_aggregator_top_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted poll merges both players' switch bytes, one lane per player
// (the second only while enabled), and emits zero, one or two packets (player
// one first, the final packet of the poll flagged by last_packet). A poll is
// accepted in any cycle in which the four-entry packet queue has room for two
// packets, even while the output is stalled. Packets leave at one per cycle
// while out_stall is low; the single read port of the packet queue sets that
// rate. Configuration writes take effect on the next cycle.
module joystick_frame_aggregator_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration port
    input  wire logic                           cfg_wr_en,
    input  wire logic [jfa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [jfa_pkg::PERIOD_W-1:0]   cfg_data,
    // poll input
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [jfa_pkg::TIME_W-1:0]     now_ms,
    input  wire logic [jfa_pkg::BYTE_W-1:0]     first_player_dir_byte,
    input  wire logic [jfa_pkg::BYTE_W-1:0]     first_player_btn_byte,
    input  wire logic [jfa_pkg::BYTE_W-1:0]     second_player_dir_byte,
    input  wire logic [jfa_pkg::BYTE_W-1:0]     second_player_btn_byte,
    // packet output
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic                                player_index,
    output logic [jfa_pkg::BYTE_W-1:0]          command_byte,
    output logic [jfa_pkg::BYTE_W-1:0]          switch_byte,
    output logic [jfa_pkg::BYTE_W-1:0]          button_byte,
    output logic                                last_packet
);
    import jfa_pkg::*;

    `include "joystick_frame_aggregator_top_macros.svh"

    logic                p2_enable_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [BYTE_W-1:0]   p1_prefix_reg;
    logic [BYTE_W-1:0]   p2_prefix_reg;

    logic          accept;
    logic          pop;
    jfa_lane_res_t res0, res1;
    jfa_pkt_t      head;
    jfa_q_status_t q_status;

    // Decode configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_enable_reg <= 1'b1;
            period_reg    <= PERIOD_RESET;
            p1_prefix_reg <= '0;
            p2_prefix_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (jfa_reg_t'(cfg_index))
                REG_P2_ENABLE: p2_enable_reg <= cfg_data[0];
                REG_PERIOD:    period_reg    <= cfg_data;
                REG_P1_PREFIX: p1_prefix_reg <= cfg_data[BYTE_W-1:0];
                REG_P2_PREFIX: p2_prefix_reg <= cfg_data[BYTE_W-1:0];
                default:       ;
            endcase
        end
    end

    // Accept a poll while the queue has room for two packets
    assign in_stall = q_status.full;
    assign accept   = in_valid && !in_stall;

    jfa_lane u_lane0 (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (accept),
        .player_id (1'b0),
        .now_ms    (now_ms),
        .dir_byte  (first_player_dir_byte),
        .btn_byte  (first_player_btn_byte),
        .period    (period_reg),
        .prefix    (p1_prefix_reg),
        .res       (res0)
    );

    jfa_lane u_lane1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (accept && p2_enable_reg),
        .player_id (1'b1),
        .now_ms    (now_ms),
        .dir_byte  (second_player_dir_byte),
        .btn_byte  (second_player_btn_byte),
        .period    (period_reg),
        .prefix    (p2_prefix_reg),
        .res       (res1)
    );

    jfa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .res0       (res0),
        .res1       (res1),
        .pop        (pop),
        .head       (head),
        .head_valid (out_valid),
        .status     (q_status)
    );

    // Drive the output item from the queue head
    assign pop          = out_valid && !out_stall;
    assign player_index = head.player_index;
    assign command_byte = head.command_byte;
    assign switch_byte  = head.switch_byte;
    assign button_byte  = head.button_byte;
    assign last_packet  = head.last_packet;

    `JFA_ASSERT_NOW(a_room_on_accept, accept, q_status.count <= QCNT_W'(QDEPTH - 2), "poll accepted without room for two packets")
    `JFA_ASSERT_NOW(a_p2_silent_when_off, !p2_enable_reg, !res1.send, "disabled second player produced a packet")
    `JFA_ASSERT_NEXT(a_no_drop_on_stall, out_valid && out_stall, out_valid, "queued packet lost while stalled")

endmodule

`default_nettype wire

/* hw/rtl/jfa_lane.sv */
// One player lane: merges switch bytes into the frame buffer, checks the
// deadline and the repeat history, and produces that player's packet.
// Depends on jfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jfa_lane (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         step,
    input  wire logic                         player_id,
    input  wire logic [jfa_pkg::TIME_W-1:0]   now_ms,
    input  wire logic [jfa_pkg::BYTE_W-1:0]   dir_byte,
    input  wire logic [jfa_pkg::BYTE_W-1:0]   btn_byte,
    input  wire logic [jfa_pkg::PERIOD_W-1:0] period,
    input  wire logic [jfa_pkg::BYTE_W-1:0]   prefix,
    output jfa_pkg::jfa_lane_res_t            res
);
    import jfa_pkg::*;

    logic [BYTE_W-1:0] dir_buf_reg, dir_buf_next;
    logic [BYTE_W-1:0] btn_buf_reg, btn_buf_next;
    logic [BYTE_W-1:0] dir_last_reg, btn_last_reg;
    logic [BYTE_W-1:0] dir_before_reg, btn_before_reg;
    logic [TIME_W-1:0] deadline_reg, deadline_next;

    logic [BYTE_W-1:0] d_clean;
    logic [BYTE_W-1:0] merged_dir;
    logic [BYTE_W-1:0] merged_btn;
    logic              due;
    logic              repeat_pkt;
    logic              send;

    // Drop opposing directions pressed together, then merge into the buffer
    always_comb
    begin
        d_clean = dir_byte;
        if (d_clean[DIR_UP_BIT] && d_clean[DIR_DOWN_BIT])
        begin
            d_clean[DIR_UP_BIT]   = 1'b0;
            d_clean[DIR_DOWN_BIT] = 1'b0;
        end
        if (d_clean[DIR_LEFT_BIT] && d_clean[DIR_RIGHT_BIT])
        begin
            d_clean[DIR_LEFT_BIT]  = 1'b0;
            d_clean[DIR_RIGHT_BIT] = 1'b0;
        end
        merged_dir = dir_buf_reg | d_clean;
        if (d_clean[DIR_UP_BIT])    merged_dir[DIR_DOWN_BIT]  = 1'b0;
        if (d_clean[DIR_DOWN_BIT])  merged_dir[DIR_UP_BIT]    = 1'b0;
        if (d_clean[DIR_LEFT_BIT])  merged_dir[DIR_RIGHT_BIT] = 1'b0;
        if (d_clean[DIR_RIGHT_BIT]) merged_dir[DIR_LEFT_BIT]  = 1'b0;
        merged_btn = btn_buf_reg | btn_byte;
    end

    // Deadline check and repeat suppression
    assign due        = (now_ms >= deadline_reg);
    assign repeat_pkt = (dir_last_reg == dir_before_reg) && (dir_last_reg == merged_dir) &&
                        (btn_last_reg == btn_before_reg) && (btn_last_reg == merged_btn);
    assign send       = step && due && !repeat_pkt;

    // Buffer and deadline next values
    always_comb
    begin
        dir_buf_next  = dir_buf_reg;
        btn_buf_next  = btn_buf_reg;
        deadline_next = deadline_reg;
        if (step)
        begin
            if (due)
            begin
                dir_buf_next  = '0;
                btn_buf_next  = '0;
                deadline_next = now_ms + {{(TIME_W-PERIOD_W){1'b0}}, period};
            end
            else
            begin
                dir_buf_next = merged_dir;
                btn_buf_next = merged_btn;
            end
        end
    end

    // Hold lane state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_buf_reg    <= '0;
            btn_buf_reg    <= '0;
            dir_last_reg   <= HIST_RESET;
            btn_last_reg   <= HIST_RESET;
            dir_before_reg <= HIST_RESET;
            btn_before_reg <= HIST_RESET;
            deadline_reg   <= '0;
        end
        else
        begin
            dir_buf_reg  <= dir_buf_next;
            btn_buf_reg  <= btn_buf_next;
            deadline_reg <= deadline_next;
            if (send)
            begin
                dir_before_reg <= dir_last_reg;
                btn_before_reg <= btn_last_reg;
                dir_last_reg   <= merged_dir;
                btn_last_reg   <= merged_btn;
            end
        end
    end

    // Packet for the merging stage
    always_comb
    begin
        res.send             = send;
        res.pkt.player_index = player_id;
        res.pkt.command_byte = prefix;
        res.pkt.switch_byte  = merged_dir;
        res.pkt.button_byte  = merged_btn & BTN_MASK;
        res.pkt.last_packet  = 1'b0;
    end

endmodule

`default_nettype wire

/* hw/rtl/jfa_queue.sv */
// Merging stage: orders the packets of both lanes, marks the final one of a
// poll and queues them for the output port. Depends on jfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jfa_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire jfa_pkg::jfa_lane_res_t res0,
    input  wire jfa_pkg::jfa_lane_res_t res1,
    input  wire logic                   pop,
    output jfa_pkg::jfa_pkt_t           head,
    output logic                        head_valid,
    output jfa_pkg::jfa_q_status_t      status
);
    import jfa_pkg::*;

    jfa_pkt_t mem [QDEPTH];

    logic [QAW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic [QCNT_W-1:0] push_n;
    logic [QAW-1:0]    wr_ptr_plus1;
    jfa_pkt_t          first_pkt, second_pkt;

    function automatic logic [QAW-1:0] wr_ptr_rel(input logic [QAW-1:0] p);
        wr_ptr_rel = p + {{(QAW-1){1'b0}}, 1'b1};
    endfunction

    // Order packets: player one first, final one carries the last mark
    always_comb
    begin
        first_pkt             = res0.send ? res0.pkt : res1.pkt;
        first_pkt.last_packet = !(res0.send && res1.send);
        second_pkt             = res1.pkt;
        second_pkt.last_packet = 1'b1;
    end

    assign push_n       = {{(QCNT_W-1){1'b0}}, res0.send} + {{(QCNT_W-1){1'b0}}, res1.send};
    assign wr_ptr_plus1 = wr_ptr_rel(wr_ptr_reg);
    assign wr_ptr_next  = wr_ptr_reg + push_n[QAW-1:0];
    assign rd_ptr_next  = pop ? rd_ptr_reg + {{(QAW-1){1'b0}}, 1'b1} : rd_ptr_reg;
    assign count_next   = count_reg + push_n - {{(QCNT_W-1){1'b0}}, pop};

    // Write the packets of one poll
    always_ff @(posedge clk)
    begin
        if (res0.send || res1.send)
            mem[wr_ptr_reg] <= first_pkt;
        if (res0.send && res1.send)
            mem[wr_ptr_plus1] <= second_pkt;
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head       = mem[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign status     = '{full: (count_reg > QCNT_W'(QDEPTH - 2)), count: count_reg};

endmodule

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for joystick_frame_aggregator_top: polls go in, packets are checked.
// Holds its own per-player frame model; depends only on jfa_pkg and the top level.
`timescale 1ns / 1ps

module tb;

    import jfa_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 120;
    localparam int PHASE_ITEMS  = 100;
    localparam int PRINT_LIMIT  = 50;

    // One poll as offered to the block
    typedef struct packed {
        logic [TIME_W-1:0] now;
        logic [BYTE_W-1:0] p1_dir;
        logic [BYTE_W-1:0] p1_btn;
        logic [BYTE_W-1:0] p2_dir;
        logic [BYTE_W-1:0] p2_btn;
    } poll_t;

    // Per-player frame model plus the queue of packets still owed by the block
    class packet_scoreboard;
        bit                  lane2_on;
        logic [PERIOD_W-1:0] period;
        logic [BYTE_W-1:0]   prefix [2];
        logic [BYTE_W-1:0]   dir_frame [2];
        logic [BYTE_W-1:0]   btn_frame [2];
        logic [BYTE_W-1:0]   dir_last [2];
        logic [BYTE_W-1:0]   btn_last [2];
        logic [BYTE_W-1:0]   dir_prev [2];
        logic [BYTE_W-1:0]   btn_prev [2];
        logic [TIME_W-1:0]   deadline [2];
        jfa_pkt_t            expected_packets [$];
        int                  errors;

        function new();
            lane2_on = 1'b1;
            period   = PERIOD_RESET;
            errors   = 0;
            for (int p = 0; p < 2; p++)
            begin
                prefix[p]    = '0;
                dir_frame[p] = '0;
                btn_frame[p] = '0;
                dir_last[p]  = HIST_RESET;
                btn_last[p]  = HIST_RESET;
                dir_prev[p]  = HIST_RESET;
                btn_prev[p]  = HIST_RESET;
                deadline[p]  = '0;
            end
        endfunction

        function void write_reg(jfa_reg_t idx, logic [PERIOD_W-1:0] val);
            case (idx)
                REG_P2_ENABLE: lane2_on  = val[0];
                REG_PERIOD:    period    = val;
                REG_P1_PREFIX: prefix[0] = val[BYTE_W-1:0];
                REG_P2_PREFIX: prefix[1] = val[BYTE_W-1:0];
                default: ;
            endcase
        endfunction

        // Drop opposing pairs, OR into the frame, let a new direction clear its opposite
        function void merge_lane(int p, logic [BYTE_W-1:0] d, logic [BYTE_W-1:0] b);
            logic [BYTE_W-1:0] cleaned;
            logic [BYTE_W-1:0] merged;
            cleaned = d;
            if (cleaned[DIR_UP_BIT] && cleaned[DIR_DOWN_BIT])
            begin
                cleaned[DIR_UP_BIT]   = 1'b0;
                cleaned[DIR_DOWN_BIT] = 1'b0;
            end
            if (cleaned[DIR_LEFT_BIT] && cleaned[DIR_RIGHT_BIT])
            begin
                cleaned[DIR_LEFT_BIT]  = 1'b0;
                cleaned[DIR_RIGHT_BIT] = 1'b0;
            end
            merged = dir_frame[p] | cleaned;
            if (cleaned[DIR_UP_BIT])    merged[DIR_DOWN_BIT]  = 1'b0;
            if (cleaned[DIR_DOWN_BIT])  merged[DIR_UP_BIT]    = 1'b0;
            if (cleaned[DIR_LEFT_BIT])  merged[DIR_RIGHT_BIT] = 1'b0;
            if (cleaned[DIR_RIGHT_BIT]) merged[DIR_LEFT_BIT]  = 1'b0;
            dir_frame[p] = merged;
            btn_frame[p] = btn_frame[p] | b;
        endfunction

        // Close the frame if due; queue a packet unless it repeats the last two sent
        function int serve_lane(int p, logic [TIME_W-1:0] now);
            jfa_pkt_t pkt;
            int       sent;
            sent = 0;
            if (now < deadline[p])
                return 0;
            if (!(dir_last[p] == dir_prev[p] && dir_last[p] == dir_frame[p] &&
                  btn_last[p] == btn_prev[p] && btn_last[p] == btn_frame[p]))
            begin
                pkt.player_index = p[0];
                pkt.command_byte = prefix[p];
                pkt.switch_byte  = dir_frame[p];
                pkt.button_byte  = btn_frame[p] & BTN_MASK;
                pkt.last_packet  = 1'b0;
                expected_packets.push_back(pkt);
                dir_prev[p] = dir_last[p];
                btn_prev[p] = btn_last[p];
                dir_last[p] = dir_frame[p];
                btn_last[p] = btn_frame[p];
                sent = 1;
            end
            deadline[p]  = now + {{(TIME_W-PERIOD_W){1'b0}}, period};
            dir_frame[p] = '0;
            btn_frame[p] = '0;
            return sent;
        endfunction

        function void note_poll(poll_t poll);
            int made;
            merge_lane(0, poll.p1_dir, poll.p1_btn);
            if (lane2_on)
                merge_lane(1, poll.p2_dir, poll.p2_btn);
            made = serve_lane(0, poll.now);
            if (lane2_on)
                made += serve_lane(1, poll.now);
            if (made > 0)
                expected_packets[expected_packets.size()-1].last_packet = 1'b1;
        endfunction

        function int pending();
            return expected_packets.size();
        endfunction

        // Latest deadline among the lanes in service
        function logic [TIME_W-1:0] latest_deadline();
            if (lane2_on && deadline[1] > deadline[0])
                return deadline[1];
            return deadline[0];
        endfunction

        task report(string msg);
            // keep the log short, keep counting
            if (errors < PRINT_LIMIT)
                $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_packet(jfa_pkt_t got);
            jfa_pkt_t want;
            if (expected_packets.size() == 0)
            begin
                report($sformatf("packet with nothing expected: %h", got));
                return;
            end
            want = expected_packets.pop_front();
            if (got.player_index !== want.player_index)
                report($sformatf("player_index got %0d want %0d",
                                 got.player_index, want.player_index));
            if (got.command_byte !== want.command_byte)
                report($sformatf("command_byte got %h want %h",
                                 got.command_byte, want.command_byte));
            if (got.switch_byte !== want.switch_byte)
                report($sformatf("switch_byte got %h want %h",
                                 got.switch_byte, want.switch_byte));
            if (got.button_byte !== want.button_byte)
                report($sformatf("button_byte got %h want %h",
                                 got.button_byte, want.button_byte));
            if (got.last_packet !== want.last_packet)
                report($sformatf("last_packet got %0d want %0d",
                                 got.last_packet, want.last_packet));
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    jfa_reg_t          cfg_index;
    logic [PERIOD_W-1:0] cfg_data;
    logic              in_valid;
    logic              in_stall;
    logic [TIME_W-1:0] now_ms;
    logic [BYTE_W-1:0] first_player_dir_byte;
    logic [BYTE_W-1:0] first_player_btn_byte;
    logic [BYTE_W-1:0] second_player_dir_byte;
    logic [BYTE_W-1:0] second_player_btn_byte;
    logic              out_valid;
    logic              out_stall;
    logic              player_index;
    logic [BYTE_W-1:0] command_byte;
    logic [BYTE_W-1:0] switch_byte;
    logic [BYTE_W-1:0] button_byte;
    logic              last_packet;

    packet_scoreboard sb = new();

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_request;
    logic [TIME_W-1:0] sim_ms;
    logic [BYTE_W-1:0] held_dir [2];
    logic [BYTE_W-1:0] held_btn [2];

    joystick_frame_aggregator_top i_dut (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .cfg_wr_en              (cfg_wr_en),
        .cfg_index              (cfg_index),
        .cfg_data               (cfg_data),
        .in_valid               (in_valid),
        .in_stall               (in_stall),
        .now_ms                 (now_ms),
        .first_player_dir_byte  (first_player_dir_byte),
        .first_player_btn_byte  (first_player_btn_byte),
        .second_player_dir_byte (second_player_dir_byte),
        .second_player_btn_byte (second_player_btn_byte),
        .out_valid              (out_valid),
        .out_stall              (out_stall),
        .player_index           (player_index),
        .command_byte           (command_byte),
        .switch_byte            (switch_byte),
        .button_byte            (button_byte),
        .last_packet            (last_packet)
    );

    // 4 ns clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Give up after a generous number of cycles
    initial
    begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Packet receiver: check each accepted item, stall at random or for a long hold-off
    initial
    begin
        jfa_pkt_t got;
        int       hold_left;
        hold_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got.player_index = player_index;
                got.command_byte = command_byte;
                got.switch_byte  = switch_byte;
                got.button_byte  = button_byte;
                got.last_packet  = last_packet;
                sb.check_packet(got);
            end
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Offer one poll, idling first at random; valid stays high into the next item
    task automatic send_poll(input poll_t p);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid               <= 1'b1;
        now_ms                 <= p.now;
        first_player_dir_byte  <= p.p1_dir;
        first_player_btn_byte  <= p.p1_btn;
        second_player_dir_byte <= p.p2_dir;
        second_player_btn_byte <= p.p2_btn;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_poll(p);
    endtask

    // Drop valid and wait until every owed packet has left, then the drain interval
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(jfa_reg_t idx, logic [PERIOD_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    task automatic set_config(bit en, logic [PERIOD_W-1:0] period,
                              logic [BYTE_W-1:0] pfx1, logic [BYTE_W-1:0] pfx2);
        write_reg(REG_P2_ENABLE, {{(PERIOD_W-1){1'b0}}, en});
        write_reg(REG_PERIOD, period);
        write_reg(REG_P1_PREFIX, {2'b00, pfx1});
        write_reg(REG_P2_PREFIX, {2'b00, pfx2});
        cfg_wr_en <= 1'b0;
    endtask

    function automatic poll_t mk(logic [TIME_W-1:0] now, logic [BYTE_W-1:0] d1,
                                 logic [BYTE_W-1:0] b1, logic [BYTE_W-1:0] d2,
                                 logic [BYTE_W-1:0] b2);
        poll_t p;
        p.now    = now;
        p.p1_dir = d1;
        p.p1_btn = b1;
        p.p2_dir = d2;
        p.p2_btn = b2;
        return p;
    endfunction

    function automatic logic [BYTE_W-1:0] rand_byte();
        return BYTE_W'($urandom_range(255));
    endfunction

    function automatic logic [BYTE_W-1:0] pick_dir();
        logic [BYTE_W-1:0] v;
        case ($urandom_range(3))
            0: v = 8'h00;
            1: v = rand_byte();
            2: v = 8'h3C & rand_byte();
            default: v = 8'h20 >> $urandom_range(3);
        endcase
        return v;
    endfunction

    function automatic logic [BYTE_W-1:0] pick_btn();
        logic [BYTE_W-1:0] v;
        case ($urandom_range(2))
            0: v = 8'h00;
            1: v = BTN_MASK;
            default: v = rand_byte();
        endcase
        return v;
    endfunction

    // Advance time mostly in small steps, hold switch patterns so frames repeat
    function automatic poll_t random_poll();
        poll_t             p;
        int                r;
        logic [TIME_W-1:0] jump;
        logic [TIME_W-1:0] far;
        r = $urandom_range(99);
        if (r < 2)
            sim_ms = 32'hFFFF_FFFF - $urandom_range(3000);
        else if (r < 5)
        begin
            jump = $urandom();
            if (jump > sim_ms)
                sim_ms = jump;
        end
        else
            sim_ms += $urandom_range(sb.period / 4 + 3);
        // after a wrap, catch up with the pending deadlines
        far = sb.latest_deadline();
        if (far > sim_ms && far - sim_ms > 1100)
            sim_ms = far;
        for (int k = 0; k < 2; k++)
        begin
            if ($urandom_range(99) < 25)
            begin
                held_dir[k] = pick_dir();
                held_btn[k] = pick_btn();
            end
        end
        p.now    = ($urandom_range(99) < 3) ? $urandom() : sim_ms;
        p.p1_dir = ($urandom_range(99) < 15) ? rand_byte() : held_dir[0];
        p.p1_btn = ($urandom_range(99) < 15) ? rand_byte() : held_btn[0];
        p.p2_dir = ($urandom_range(99) < 15) ? rand_byte() : held_dir[1];
        p.p2_btn = ($urandom_range(99) < 15) ? rand_byte() : held_btn[1];
        return p;
    endfunction

    initial
    begin
        bit                  en;
        logic [PERIOD_W-1:0] period;
        send_idle_pct          = 22;
        recv_idle_pct          = 54;
        hold_request           = 1'b0;
        sim_ms                 = '0;
        held_dir               = '{8'h00, 8'h00};
        held_btn               = '{8'h00, 8'h00};
        rst_n                  <= 1'b0;
        cfg_wr_en              <= 1'b0;
        cfg_index              <= REG_P2_ENABLE;
        cfg_data               <= '0;
        in_valid               <= 1'b0;
        now_ms                 <= '0;
        first_player_dir_byte  <= '0;
        first_player_btn_byte  <= '0;
        second_player_dir_byte <= '0;
        second_player_btn_byte <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Opposing pairs, clearing of the opposite, frame boundaries, repeats
        set_config(1'b1, 10'd16, 8'hA5, 8'h5A);
        send_poll(mk(32'd0,  8'h30, 8'h7F, 8'h0C, 8'h80));
        send_poll(mk(32'd5,  8'h20, 8'hFF, 8'h08, 8'h00));
        send_poll(mk(32'd9,  8'h10, 8'h00, 8'h04, 8'h01));
        send_poll(mk(32'd16, 8'h3C, 8'h00, 8'hFF, 8'hFF));
        send_poll(mk(32'd16, 8'h00, 8'h00, 8'h00, 8'h00));
        send_poll(mk(32'd32, 8'h00, 8'h00, 8'h00, 8'h00));
        send_poll(mk(32'd48, 8'h00, 8'h00, 8'h00, 8'h00));
        send_poll(mk(32'd64, 8'h00, 8'h00, 8'h00, 8'h00));
        send_poll(mk(32'd80, 8'h00, 8'h00, 8'h00, 8'h00));
        // deadline sum wraps past the top of the time range
        send_poll(mk(32'hFFFF_FFF8, 8'hC3, 8'h80, 8'h03, 8'h80));
        send_poll(mk(32'hFFFF_FFFF, 8'h00, 8'h00, 8'h00, 8'h00));
        send_poll(mk(32'd3,  8'h01, 8'h00, 8'h02, 8'h00));
        send_poll(mk(32'd15, 8'h40, 8'h80, 8'h80, 8'h7F));
        wait_drained();

        // Second player off, zero period: every poll is due
        set_config(1'b0, 10'd0, 8'hFF, 8'h00);
        send_poll(mk(32'd20, 8'h24, 8'h80, 8'hFF, 8'hFF));
        send_poll(mk(32'd20, 8'h24, 8'h80, 8'hFF, 8'hFF));
        send_poll(mk(32'd20, 8'h24, 8'h80, 8'hFF, 8'hFF));
        send_poll(mk(32'd21, 8'h00, 8'h00, 8'h00, 8'h00));
        wait_drained();

        // Longest period, second player back on
        set_config(1'b1, 10'd1023, 8'h00, 8'hFF);
        send_poll(mk(32'd100,  8'hFF, 8'hFF, 8'h18, 8'h7F));
        send_poll(mk(32'd1122, 8'h14, 8'h80, 8'h28, 8'h00));
        send_poll(mk(32'd1123, 8'h01, 8'h00, 8'h02, 8'h00));
        send_poll(mk(32'h8000_0000, 8'hAA, 8'h55, 8'h55, 8'hAA));
        sim_ms = 32'h8000_0000;

        // Random phases over several settings and idling patterns
        for (int ph = 0; ph < 6; ph++)
        begin
            wait_drained();
            send_idle_pct = (ph < 2) ? 22 : (ph < 4) ? 54 : 0;
            recv_idle_pct = (ph < 2) ? 54 : (ph < 4) ? 22 : 0;
            case (ph)
                0: begin en = 1'b1; period = 10'd16;   end
                1: begin en = 1'b0; period = 10'd1;    end
                2: begin en = 1'b1; period = 10'd1000; end
                3: begin en = 1'b1; period = 10'd1023; end
                4: begin en = 1'b1; period = PERIOD_W'($urandom_range(2, 40)); end
                default: begin en = 1'($urandom_range(1)); period = 10'd3; end
            endcase
            set_config(en, period, rand_byte(), rand_byte());
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // hold the receiver off so the block backs up into its input
                if (k == 30)
                    hold_request = 1'b1;
                // pause the sender until every owed packet has arrived
                if (k == 65)
                    wait_drained();
                send_poll(random_poll());
            end
        end

        wait_drained();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
